### hdl/mpc_pkg.sv
// Shared constants and types for the moon phase calculator.
package mpc_pkg;

	// Field widths
	localparam int TIME_W  = 40;
	localparam int LEN_W   = 38;
	localparam int FRAC_W  = 16;
	localparam int PHASE_W = 16;
	localparam int NAME_W  = 3;
	localparam int MAG_W   = TIME_W + 1;
	localparam int CFG_W   = 64;
	localparam int ADDR_W  = 4;

	// Pipeline lengths
	localparam int MOD_STEPS  = MAG_W + FRAC_W;
	localparam int QUOT_STEPS = PHASE_W;
	localparam int ILL_STAGES = 13;

	// Register reset values
	localparam logic [TIME_W-1:0]  EPOCH_RST = 40'd947182440;
	localparam logic [LEN_W-1:0]   LEN_RST   = 38'd167211360380;
	localparam logic [LEN_W+1:0]   LEN3_RST  = 40'd501634081140;

	// Fixed point constants of the sine polynomial (Q30)
	localparam int ACC_W = 31;
	localparam int TH_W  = 30;
	localparam logic [31:0]      PI_Q30  = 32'd3373259426;
	localparam logic [ACC_W-1:0] ONE_Q30 = 31'd1073741824;

	// Reciprocals for exact division of 30-bit values by small constants
	localparam int SH_72 = 37;
	localparam int SH_42 = 36;
	localparam int SH_20 = 35;
	localparam int SH_6  = 33;
	localparam logic [ACC_W-1:0] RCP_72 = 31'(((64'd1 << SH_72) + 64'd71) / 64'd72);
	localparam logic [ACC_W-1:0] RCP_42 = 31'(((64'd1 << SH_42) + 64'd41) / 64'd42);
	localparam logic [ACC_W-1:0] RCP_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
	localparam logic [ACC_W-1:0] RCP_6  = 31'(((64'd1 << SH_6) + 64'd5) / 64'd6);

	// Register map
	typedef enum logic {
		REG_EPOCH = 1'b0,
		REG_LEN   = 1'b1
	} reg_idx_t;

endpackage

### hdl/mpc_if.sv
// Query and result channel interfaces.
interface mpc_in_if;
	import mpc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TIME_W-1:0] unix_time;

	modport source (output valid, output unix_time, input ready);
	modport sink (input valid, input unix_time, output ready);
endinterface

interface mpc_out_if;
	import mpc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [LEN_W-1:0]         age_seconds;
	logic [PHASE_W-1:0]       phase_fraction;
	logic [PHASE_W-1:0]       illuminated_fraction;
	logic [NAME_W-1:0]        phase_name_index;
	logic signed [TIME_W-1:0] next_new_moon;
	logic signed [TIME_W-1:0] next_full_moon;

	modport source (output valid, output age_seconds, output phase_fraction,
		output illuminated_fraction, output phase_name_index, output next_new_moon,
		output next_full_moon, input ready);
	modport sink (input valid, input age_seconds, input phase_fraction,
		input illuminated_fraction, input phase_name_index, input next_new_moon,
		input next_full_moon, output ready);
endinterface

### hdl/mpc_cell.sv
// One restoring remainder cell: shifts in a dividend bit, subtracts the month if it fits.
module mpc_cell #(
	parameter int W  = mpc_pkg::LEN_W,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [W-1:0]  len,
	input  logic          in_v,
	input  logic [W-1:0]  in_rem,
	input  logic          in_bit,
	input  logic [SW-1:0] in_side,
	output logic          out_v,
	output logic [W-1:0]  out_rem,
	output logic          out_qbit,
	output logic [SW-1:0] out_side
);
	logic [W:0]    shifted;
	logic [W+1:0]  diff;
	logic          ge;
	logic          v_q;
	logic [W-1:0]  rem_q;
	logic          qb_q;
	logic [SW-1:0] side_q;

	// trial subtract
	assign shifted = {in_rem, in_bit};
	assign diff    = {1'b0, shifted} - {2'b00, len};
	assign ge      = ~diff[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[W-1:0] : shifted[W-1:0];
			qb_q   <= ge;
			side_q <= in_side;
		end
	end

	assign out_v    = v_q;
	assign out_rem  = rem_q;
	assign out_qbit = qb_q;
	assign out_side = side_q;
endmodule

### hdl/mpc_illum.sv
// Illuminated fraction pipeline: sin^2 polynomial over a quarter wave, at most one multiply per stage.
module mpc_illum #(
	parameter int SW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  logic [mpc_pkg::PHASE_W-1:0] in_phase,
	input  logic [SW-1:0]               in_side,
	output logic                        out_v,
	output logic [mpc_pkg::PHASE_W-1:0] out_illum,
	output logic [SW-1:0]               out_side
);
	import mpc_pkg::*;

	localparam int LAST = ILL_STAGES - 1;
	localparam logic [PHASE_W:0] HALF_TURN = (PHASE_W+1)'(1) << (PHASE_W - 1);
	localparam logic [PHASE_W:0] FULL_TURN = (PHASE_W+1)'(1) << PHASE_W;
	localparam logic [PHASE_W:0] QUARTER   = (PHASE_W+1)'(1) << (PHASE_W - 2);

	typedef struct packed {
		logic             inv;
		logic [TH_W-1:0]  th;
		logic [TH_W-1:0]  t2;
		logic [ACC_W-1:0] acc;
	} ill_t;

	logic          v_q    [ILL_STAGES];
	logic [SW-1:0] side_q [ILL_STAGES];
	ill_t          st_q   [ILL_STAGES];
	ill_t          nxt    [ILL_STAGES];

	// stage logic
	always_comb begin
		logic [PHASE_W:0] q;
		logic [PHASE_W:0] r;
		logic             inv;
		logic [46:0]      p_th;
		logic [59:0]      p_t2;
		logic [60:0]      p3, p4, p5, p6, p7, p8, p9, p10, p11;
		logic [ACC_W-1:0] rnd;
		logic [PHASE_W:0] v;
		logic [PHASE_W:0] w;

		// fold phase into a quarter wave
		q   = ({1'b0, in_phase} <= HALF_TURN) ? {1'b0, in_phase} : FULL_TURN - {1'b0, in_phase};
		inv = q > QUARTER;
		r   = inv ? HALF_TURN - q : q;
		nxt[0]     = '0;
		nxt[0].inv = inv;
		nxt[0].acc = ACC_W'(r);

		for (int k = 1; k < ILL_STAGES; k++) begin
			nxt[k] = st_q[k-1];
		end

		// theta = r * pi / 65536
		p_th = 47'(st_q[0].acc) * 47'(PI_Q30);
		nxt[1].th = p_th[45:16];
		// theta squared
		p_t2 = 60'(st_q[1].th) * 60'(st_q[1].th);
		nxt[2].t2 = p_t2[59:30];
		// Horner steps of the sine series
		p3 = 61'(st_q[2].t2) * 61'(RCP_72);
		nxt[3].acc = ONE_Q30 - ACC_W'(p3 >> SH_72);
		p4 = 61'(st_q[3].t2) * 61'(st_q[3].acc);
		nxt[4].acc = ACC_W'(p4 >> 30);
		p5 = 61'(st_q[4].acc) * 61'(RCP_42);
		nxt[5].acc = ONE_Q30 - ACC_W'(p5 >> SH_42);
		p6 = 61'(st_q[5].t2) * 61'(st_q[5].acc);
		nxt[6].acc = ACC_W'(p6 >> 30);
		p7 = 61'(st_q[6].acc) * 61'(RCP_20);
		nxt[7].acc = ONE_Q30 - ACC_W'(p7 >> SH_20);
		p8 = 61'(st_q[7].t2) * 61'(st_q[7].acc);
		nxt[8].acc = ACC_W'(p8 >> 30);
		p9 = 61'(st_q[8].acc) * 61'(RCP_6);
		nxt[9].acc = ONE_Q30 - ACC_W'(p9 >> SH_6);
		// sine, then its square
		p10 = 61'(st_q[9].th) * 61'(st_q[9].acc);
		nxt[10].acc = ACC_W'(p10 >> 30);
		p11 = 61'(st_q[10].acc) * 61'(st_q[10].acc);
		nxt[11].acc = ACC_W'(p11 >> 30);
		// round to 16 bits, mirror, saturate
		rnd = st_q[11].acc + ACC_W'(1 << 13);
		v   = rnd[PHASE_W+14:14];
		w   = st_q[11].inv ? FULL_TURN - v : v;
		nxt[12].acc = w[PHASE_W] ? ACC_W'({PHASE_W{1'b1}}) : ACC_W'(w[PHASE_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ILL_STAGES; k++) begin
				v_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_q[0] <= in_v;
			for (int k = 1; k < ILL_STAGES; k++) begin
				v_q[k] <= v_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= in_side;
			for (int k = 1; k < ILL_STAGES; k++) begin
				side_q[k] <= side_q[k-1];
			end
			for (int k = 0; k < ILL_STAGES; k++) begin
				st_q[k] <= nxt[k];
			end
		end
	end

	assign out_v     = v_q[LAST];
	assign out_side  = side_q[LAST];
	assign out_illum = st_q[LAST].acc[PHASE_W-1:0];
endmodule

### hdl/moon_phase_calculator.sv
// Moon phase calculator top level: config registers, cell chains and output skid.
//
// Usage:
//   query  : valid/ready channel carrying a signed Unix second (unix_time).
//   result : valid/ready channel carrying age, phase, illuminated fraction,
//            phase name index and the next new and full moon seconds.
//   APB    : register 0 (byte 0x0) reference epoch, register 1 (byte 0x8)
//            lunation length in seconds with 16 fraction bits. Write only
//            while no query is in flight.
// Pipeline: 57 remainder cells for the age modulo the month, 16 quotient
//   cells for the phase, 13 stages of the illumination polynomial, plus five
//   stage registers and the output register.
// Throughput: one query per cycle while the skid register is empty; the
//   remainder and quotient cells and polynomial stages advance only then.
// Reset clears all valid bits and loads the default epoch and month length.
// When the receiver stalls, the output register holds its result and a skid
//   register takes one more; after that the whole pipeline and the query
//   channel hold until the result is taken.
module moon_phase_calculator (
	input  logic                       clk,
	input  logic                       arst_n,
	mpc_in_if.sink                     query,
	mpc_out_if.source                  result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mpc_pkg::ADDR_W-1:0] paddr,
	input  logic [mpc_pkg::CFG_W-1:0]  pwdata,
	output logic [mpc_pkg::CFG_W-1:0]  prdata,
	output logic                       pready
);
	import mpc_pkg::*;

	localparam int SN_W = LEN_W + 1 - FRAC_W;
	localparam int SF_W = LEN_W + 2 - FRAC_W;
	localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic              neg;
		logic [MAG_W-1:0]  mag;
	} mod_side_t;

	typedef struct packed {
		logic [TIME_W-1:0]  t;
		logic [LEN_W-1:0]   age;
		logic [PHASE_W-1:0] qacc;
	} quo_side_t;

	typedef struct packed {
		logic [TIME_W-1:0]  t;
		logic [LEN_W-1:0]   age;
		logic [PHASE_W-1:0] phase;
		logic [LEN_W-1:0]   off_new;
		logic [LEN_W+1:0]   off_full;
	} ill_side_t;

	typedef struct packed {
		logic [LEN_W-1:0]   age;
		logic [PHASE_W-1:0] phase;
		logic [PHASE_W-1:0] illum;
		logic [NAME_W-1:0]  name;
		logic [TIME_W-1:0]  new_at;
		logic [TIME_W-1:0]  full_at;
	} res_t;

	// ---------------- configuration ----------------
	logic [TIME_W-1:0] epoch_q;
	logic [LEN_W-1:0]  lun_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W+1:0]  len3_q;
	logic              cfg_wr;
	reg_idx_t          sel;
	logic [LEN_W-1:0]  wlen;

	assign cfg_wr = psel & penable & pwrite;
	assign sel    = reg_idx_t'(paddr[ADDR_W-1]);
	assign pready = 1'b1;
	// zero month length counts as one
	assign wlen   = (pwdata[LEN_W-1:0] == '0) ? LEN_W'(1) : pwdata[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= EPOCH_RST;
			lun_q   <= LEN_RST;
			len_q   <= LEN_RST;
			len3_q  <= LEN3_RST;
		end else if (cfg_wr) begin
			case (sel)
				REG_EPOCH: epoch_q <= pwdata[TIME_W-1:0];
				REG_LEN: begin
					lun_q  <= pwdata[LEN_W-1:0];
					len_q  <= wlen;
					len3_q <= {1'b0, wlen, 1'b0} + {2'b00, wlen};
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_EPOCH: prdata = CFG_W'(epoch_q);
			REG_LEN:   prdata = CFG_W'(lun_q);
			default:   prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	logic pipe_en;
	logic skid_v_q;

	assign pipe_en     = ~skid_v_q;
	assign query.ready = pipe_en;

	// ---------------- stage 1: distance from epoch ----------------
	logic              v_s1;
	logic [TIME_W-1:0] t_s1;
	logic [MAG_W-1:0]  d_s1;
	logic              neg_s1;
	logic [MAG_W-1:0]  mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= query.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			t_s1 <= query.unix_time;
			d_s1 <= {query.unix_time[TIME_W-1], query.unix_time} - {epoch_q[TIME_W-1], epoch_q};
		end
	end

	assign neg_s1 = d_s1[MAG_W-1];
	assign mag_s1 = neg_s1 ? (~d_s1 + MAG_W'(1)) : d_s1;

	// ---------------- remainder chain: |d| * 2^16 mod month ----------------
	logic             mod_v    [MOD_STEPS];
	logic [LEN_W-1:0] mod_rem  [MOD_STEPS];
	mod_side_t        mod_side [MOD_STEPS];

	for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
		logic             c_v;
		logic [LEN_W-1:0] c_rem;
		logic             c_bit;
		mod_side_t        c_side;

		if (k == 0) begin : g_first
			assign c_v    = v_s1;
			assign c_rem  = '0;
			assign c_side = '{t: t_s1, neg: neg_s1, mag: mag_s1};
			assign c_bit  = mag_s1[MAG_W-1];
		end else begin : g_next
			assign c_v    = mod_v[k-1];
			assign c_rem  = mod_rem[k-1];
			assign c_side = mod_side[k-1];
			if (k < MAG_W) begin : g_bit
				assign c_bit = mod_side[k-1].mag[MAG_W-1-k];
			end else begin : g_zero
				assign c_bit = 1'b0;
			end
		end

		mpc_cell #(
			.W  (LEN_W),
			.SW ($bits(mod_side_t))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (pipe_en),
			.len      (len_q),
			.in_v     (c_v),
			.in_rem   (c_rem),
			.in_bit   (c_bit),
			.in_side  (c_side),
			.out_v    (mod_v[k]),
			.out_rem  (mod_rem[k]),
			.out_qbit (),
			.out_side (mod_side[k])
		);
	end

	// ---------------- stage 2: floor-mod fixup for negative distance ----------------
	logic              v_s2;
	logic [TIME_W-1:0] t_s2;
	logic [LEN_W-1:0]  age_s2;
	logic [LEN_W-1:0]  mod_r;
	mod_side_t         mod_last;

	assign mod_r    = mod_rem[MOD_STEPS-1];
	assign mod_last = mod_side[MOD_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (pipe_en) begin
			v_s2 <= mod_v[MOD_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			t_s2   <= mod_last.t;
			age_s2 <= (mod_last.neg && mod_r != '0) ? len_q - mod_r : mod_r;
		end
	end

	// ---------------- quotient chain: age * 2^16 / month ----------------
	logic             quo_v    [QUOT_STEPS];
	logic [LEN_W-1:0] quo_rem  [QUOT_STEPS];
	logic             quo_qb   [QUOT_STEPS];
	quo_side_t        quo_side [QUOT_STEPS];

	for (genvar j = 0; j < QUOT_STEPS; j++) begin : g_quo
		logic             c_v;
		logic [LEN_W-1:0] c_rem;
		quo_side_t        c_side;

		if (j == 0) begin : g_first
			assign c_v    = v_s2;
			assign c_rem  = age_s2;
			assign c_side = '{t: t_s2, age: age_s2, qacc: '0};
		end else begin : g_next
			assign c_v    = quo_v[j-1];
			assign c_rem  = quo_rem[j-1];
			assign c_side = '{t: quo_side[j-1].t, age: quo_side[j-1].age,
				qacc: {quo_side[j-1].qacc[PHASE_W-2:0], quo_qb[j-1]}};
		end

		mpc_cell #(
			.W  (LEN_W),
			.SW ($bits(quo_side_t))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (pipe_en),
			.len      (len_q),
			.in_v     (c_v),
			.in_rem   (c_rem),
			.in_bit   (1'b0),
			.in_side  (c_side),
			.out_v    (quo_v[j]),
			.out_rem  (quo_rem[j]),
			.out_qbit (quo_qb[j]),
			.out_side (quo_side[j])
		);
	end

	// ---------------- stage 3: phase and distances to the next events ----------------
	logic             v_s3;
	ill_side_t        side_s3;
	quo_side_t        quo_last;
	logic [LEN_W:0]   two_a;
	logic             before_full;

	assign quo_last    = quo_side[QUOT_STEPS-1];
	assign two_a       = {quo_last.age, 1'b0};
	assign before_full = two_a < {1'b0, len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (pipe_en) begin
			v_s3 <= quo_v[QUOT_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s3.t        <= quo_last.t;
			side_s3.age      <= quo_last.age;
			side_s3.phase    <= {quo_last.qacc[PHASE_W-2:0], quo_qb[QUOT_STEPS-1]};
			side_s3.off_new  <= len_q - quo_last.age;
			side_s3.off_full <= before_full ? (LEN_W+2)'({1'b0, len_q} - two_a)
			                                : len3_q - (LEN_W+2)'(two_a);
		end
	end

	// ---------------- illumination ----------------
	logic               ill_v;
	logic [PHASE_W-1:0] ill_val;
	ill_side_t          ill_side;

	mpc_illum #(
		.SW ($bits(ill_side_t))
	) u_illum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_v      (v_s3),
		.in_phase  (side_s3.phase),
		.in_side   (side_s3),
		.out_v     (ill_v),
		.out_illum (ill_val),
		.out_side  (ill_side)
	);

	// ---------------- stage 4: whole seconds, name index ----------------
	logic               v_s4;
	logic [TIME_W-1:0]  t_s4;
	logic [LEN_W-1:0]   age_s4;
	logic [PHASE_W-1:0] phase_s4;
	logic [PHASE_W-1:0] illum_s4;
	logic [NAME_W-1:0]  name_s4;
	logic [SN_W-1:0]    sn_s4;
	logic [SF_W-1:0]    sf_s4;
	logic [LEN_W:0]     sum_new;
	logic [LEN_W+2:0]   sum_full;
	logic [NAME_W+1:0]  name_rnd;

	assign sum_new  = {1'b0, ill_side.off_new} + (LEN_W+1)'((1 << FRAC_W) - 1);
	assign sum_full = {1'b0, ill_side.off_full} + (LEN_W+3)'((1 << (FRAC_W + 1)) - 1);
	// nearest of eight names, wrapping past the last
	assign name_rnd = {1'b0, ill_side.phase[PHASE_W-1 -: NAME_W+1]} + (NAME_W+2)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (pipe_en) begin
			v_s4 <= ill_v;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			t_s4     <= ill_side.t;
			age_s4   <= ill_side.age;
			phase_s4 <= ill_side.phase;
			illum_s4 <= ill_val;
			name_s4  <= name_rnd[NAME_W:1];
			sn_s4    <= sum_new[LEN_W:FRAC_W];
			sf_s4    <= sum_full[LEN_W+2:FRAC_W+1];
		end
	end

	// ---------------- stage 5: event times with saturation ----------------
	logic            v_s5;
	res_t            res_s5;
	logic [TIME_W:0] ev_new;
	logic [TIME_W:0] ev_full;

	assign ev_new  = {t_s4[TIME_W-1], t_s4} + (TIME_W+1)'(sn_s4);
	assign ev_full = {t_s4[TIME_W-1], t_s4} + (TIME_W+1)'(sf_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (pipe_en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			res_s5.age     <= age_s4;
			res_s5.phase   <= phase_s4;
			res_s5.illum   <= illum_s4;
			res_s5.name    <= name_s4;
			res_s5.new_at  <= (~ev_new[TIME_W] & ev_new[TIME_W-1]) ? TIME_MAX
			                                                        : ev_new[TIME_W-1:0];
			res_s5.full_at <= (~ev_full[TIME_W] & ev_full[TIME_W-1]) ? TIME_MAX
			                                                          : ev_full[TIME_W-1:0];
		end
	end

	// ---------------- output register and skid ----------------
	logic out_v_q;
	res_t out_q;
	res_t skid_q;
	logic up_fire;
	logic out_fire;

	assign up_fire  = v_s5 & pipe_en;
	assign out_fire = out_v_q & result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_fire || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= up_fire;
			end
		end else if (up_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_v_q) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (up_fire) begin
				out_q <= res_s5;
			end
		end else if (up_fire) begin
			skid_q <= res_s5;
		end
	end

	assign result.valid                = out_v_q;
	assign result.age_seconds          = out_q.age;
	assign result.phase_fraction       = out_q.phase;
	assign result.illuminated_fraction = out_q.illum;
	assign result.phase_name_index     = out_q.name;
	assign result.next_new_moon        = out_q.new_at;
	assign result.next_full_moon       = out_q.full_at;
endmodule

### verif/mpc_tb_if.sv
`timescale 1ns / 1ps
// Result record type used by the testbench predictor and monitor.
package mpc_tb_types;
	import mpc_pkg::*;

	// One predicted moon phase result
	typedef struct packed {
		logic [LEN_W-1:0]         age;
		logic [PHASE_W-1:0]       phase;
		logic [PHASE_W-1:0]       lit;
		logic [NAME_W-1:0]        name;
		logic signed [TIME_W-1:0] new_moon;
		logic signed [TIME_W-1:0] full_moon;
	} moon_result_t;
endpackage

### verif/moon_phase_calculator_tb.sv
`timescale 1ns / 1ps
// Testbench for the moon phase calculator: directed and random query streams checked against a predictor.
module moon_phase_calculator_tb;
	import mpc_pkg::*;
	import mpc_tb_types::*;

	localparam int  LIMIT    = 400000;
	localparam longint TMAX  = (64'sd1 <<< (TIME_W - 1)) - 1;
	localparam longint TMIN  = -(64'sd1 <<< (TIME_W - 1));

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [CFG_W-1:0]  pwdata;
	logic [CFG_W-1:0]  prdata;
	logic              pready;

	mpc_in_if  qi ();
	mpc_out_if ro ();

	moon_phase_calculator dut (
		.clk(clk), .arst_n(arst_n), .query(qi.sink), .result(ro.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor copy of the configuration
	logic signed [TIME_W-1:0] cur_epoch;
	logic [LEN_W-1:0]         cur_len;

	logic signed [TIME_W-1:0] pending_times[$];
	moon_result_t             awaited_moons[$];
	int  mismatches;
	int  cycles;
	int  idle_mode;   // 0: sender 36 / receiver 46, 1: swapped, 2: none
	bit  in_xfer;

	// Clock
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// sin^2(pi*r/65536) for r in [0, 16384], 16-bit fraction
	function automatic logic [63:0] sine_squared(input logic [63:0] r);
		logic [63:0] th, t2, a, s, s2;
		th = (r * 64'd3373259426) >> 16;
		t2 = (th * th) >> 30;
		a  = 64'd1073741824 - t2 / 72;
		a  = 64'd1073741824 - ((t2 * a) >> 30) / 42;
		a  = 64'd1073741824 - ((t2 * a) >> 30) / 20;
		a  = 64'd1073741824 - ((t2 * a) >> 30) / 6;
		s  = (th * a) >> 30;
		s2 = (s * s) >> 30;
		return (s2 + 64'd8192) >> 14;
	endfunction

	function automatic logic [63:0] lit_fraction(input logic [63:0] p);
		logic [63:0] q, v;
		q = (p <= 64'd32768) ? p : 64'd65536 - p;
		v = (q <= 64'd16384) ? sine_squared(q) : 64'd65536 - sine_squared(64'd32768 - q);
		return (v > 64'd65535) ? 64'd65535 : v;
	endfunction

	function automatic longint wrap_mod(input longint v, input longint m);
		longint r;
		r = v % m;
		if (r < 0) r += m;
		return r;
	endfunction

	function automatic logic [TIME_W-1:0] saturating_event(input longint t, input longint secs);
		return (t > TMAX - secs) ? TIME_W'(TMAX) : TIME_W'(t + secs);
	endfunction

	function automatic moon_result_t predict_moon(input logic signed [TIME_W-1:0] ut);
		moon_result_t res;
		longint t, e, len;
		logic [63:0] dm, age, phase, off_new, off_full, sn, sf;
		len = (cur_len == 0) ? 64'sd1 : longint'({26'd0, cur_len});
		t = ut;
		e = cur_epoch;
		dm  = (wrap_mod(t, len) + len - wrap_mod(e, len)) % len;
		age = (dm << FRAC_W) % len;
		phase = (age << 16) / len;
		off_new  = len - age;
		sn = (off_new + 64'd65535) >> FRAC_W;
		off_full = (2 * age < len) ? len - 2 * age : 3 * len - 2 * age;
		sf = (off_full + 64'd131071) >> (FRAC_W + 1);
		res.age   = age[LEN_W-1:0];
		res.phase = phase[15:0];
		res.lit   = PHASE_W'(lit_fraction(phase) & 64'hFFFF);
		res.name  = 3'(((age * 16 + len) / (2 * len)) % 8);
		res.new_moon  = saturating_event(t, sn);
		res.full_moon = saturating_event(t, sf);
		return res;
	endfunction

	// Query driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qi.valid     <= 1'b0;
			qi.unix_time <= '0;
		end else if (in_xfer || !qi.valid) begin
			if (pending_times.size() == 0 ||
					(idle_mode == 0 && $urandom_range(0, 99) < 36) ||
					(idle_mode == 1 && $urandom_range(0, 99) < 46)) begin
				qi.valid <= 1'b0;
			end else begin
				qi.valid     <= 1'b1;
				qi.unix_time <= pending_times.pop_front();
			end
		end
	end

	// Result receiver stalls
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro.ready <= 1'b0;
		end else begin
			ro.ready <= !((idle_mode == 0 && $urandom_range(0, 99) < 46) ||
				(idle_mode == 1 && $urandom_range(0, 99) < 36));
		end
	end

	// Monitor: predict on query transfer, check on result transfer
	always @(posedge clk) begin
		moon_result_t exp_r, got;
		in_xfer <= arst_n && qi.valid && qi.ready;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (cycles > LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
			if (qi.valid && qi.ready)
				awaited_moons.push_back(predict_moon(qi.unix_time));
			if (ro.valid && ro.ready) begin
				got = '{ro.age_seconds, ro.phase_fraction, ro.illuminated_fraction,
					ro.phase_name_index, ro.next_new_moon, ro.next_full_moon};
				if (awaited_moons.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", got);
				end else begin
					exp_r = awaited_moons.pop_front();
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", exp_r, got);
					end
				end
			end
		end
	end

	// APB register write: setup then access
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(8 * int'(idx)); pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_EPOCH) cur_epoch = val[TIME_W-1:0];
		else cur_len = val[LEN_W-1:0];
	endtask

	// Sender holds until every result is back and the pipeline is empty
	task automatic drain_all();
		while (pending_times.size() != 0 || qi.valid || awaited_moons.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic signed [TIME_W-1:0] pick_time();
		longint secs, base;
		secs = (cur_len >> FRAC_W) + 1;
		base = cur_epoch;
		case ($urandom_range(0, 9))
			0, 1, 2: return TIME_W'(base + longint'($urandom_range(0, 4000)) * secs
				- 2000 * secs + $signed($urandom_range(0, 20)) - 10);
			3:       return TIME_W'(base + secs / 2 + $signed($urandom_range(0, 4)) - 2);
			4, 5:    return TIME_W'({$urandom, $urandom});
			6:       return TIME_W'(TMAX - longint'($urandom_range(0, 3)) * secs
				- $urandom_range(0, 50));
			7:       return TIME_W'(TMIN + $urandom_range(0, 1000));
			default: return TIME_W'(base + $signed($urandom) / 4);
		endcase
	endfunction

	task automatic run_random(input int n);
		repeat (n) pending_times.push_back(pick_time());
		drain_all();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		mismatches = 0; cycles = 0; idle_mode = 0; in_xfer = 1'b0;
		cur_epoch = EPOCH_RST;
		cur_len   = LEN_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, epoch neighborhood, half month, saturation
		pending_times.push_back(TIME_W'(TMIN));
		pending_times.push_back(TIME_W'(TMAX));
		pending_times.push_back('0);
		pending_times.push_back(-40'sd1);
		pending_times.push_back(cur_epoch);
		pending_times.push_back(cur_epoch + 1);
		pending_times.push_back(cur_epoch - 1);
		pending_times.push_back(cur_epoch - 40'sd2551443);
		pending_times.push_back(cur_epoch + 40'sd1275721);
		pending_times.push_back(cur_epoch + 40'sd1275722);
		pending_times.push_back(TIME_W'(TMAX - 1000));
		pending_times.push_back(TIME_W'(TMAX - 2000000));
		drain_all();
		write_reg(REG_EPOCH, CFG_W'(TMAX));
		write_reg(REG_LEN, CFG_W'({LEN_W{1'b1}}));
		pending_times.push_back(TIME_W'(TMAX));
		pending_times.push_back(TIME_W'(TMIN));
		pending_times.push_back('0);
		drain_all();
		write_reg(REG_LEN, '0);
		pending_times.push_back(TIME_W'(TMAX));
		pending_times.push_back(40'sd12345);
		drain_all();
		write_reg(REG_LEN, 64'd1);
		write_reg(REG_EPOCH, CFG_W'(TMIN));
		pending_times.push_back(TIME_W'(TMAX));
		pending_times.push_back(TIME_W'(TMIN));
		pending_times.push_back(-40'sd7);
		drain_all();

		// Random groups over several settings and idle patterns
		write_reg(REG_EPOCH, CFG_W'(EPOCH_RST));
		write_reg(REG_LEN, CFG_W'(LEN_RST));
		run_random(100);
		write_reg(REG_EPOCH, CFG_W'(TMAX));
		write_reg(REG_LEN, CFG_W'({LEN_W{1'b1}}));
		run_random(100);
		write_reg(REG_EPOCH, CFG_W'(TMIN));
		write_reg(REG_LEN, 64'd1);
		run_random(100);
		idle_mode = 1;
		write_reg(REG_LEN, '0);
		run_random(60);
		write_reg(REG_EPOCH, {$urandom, $urandom});
		write_reg(REG_LEN, CFG_W'({$urandom_range(1, 63), $urandom}));
		run_random(140);
		idle_mode = 2;
		write_reg(REG_EPOCH, '0);
		write_reg(REG_LEN, CFG_W'(64'd65536 * $urandom_range(1, 100) + $urandom_range(0, 65535)));
		run_random(100);
		write_reg(REG_EPOCH, CFG_W'(EPOCH_RST));
		write_reg(REG_LEN, CFG_W'(LEN_RST));
		run_random(100);

		if (mismatches == 0 && awaited_moons.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

### sim.f
hdl/mpc_pkg.sv
hdl/mpc_if.sv
hdl/mpc_cell.sv
hdl/mpc_illum.sv
hdl/moon_phase_calculator.sv
verif/mpc_tb_if.sv
verif/moon_phase_calculator_tb.sv
